// ===== hdl/next_present_slot_finder_top_assert.svh =====
// Assertion macros for the next present slot finder.
`ifndef NEXT_PRESENT_SLOT_FINDER_TOP_ASSERT_SVH
`define NEXT_PRESENT_SLOT_FINDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/nps_pkg.sv =====
// Shared constants, types and bit helpers for the next present slot finder.
`default_nettype none

package nps_pkg;

	localparam int unsigned POS_W     = 10;
	localparam int unsigned POS_SLOTS = 1 << POS_W;
	localparam int unsigned OFS_W     = 5;
	localparam int unsigned WORD_BITS = 1 << OFS_W;
	localparam int unsigned WIDX_W    = POS_W - OFS_W;
	localparam int unsigned DEF_SLOTS = 1024;
	localparam int unsigned TDATA_W   = 16;

	localparam logic ACT_QUERY  = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_EVAL1,
		ST_EVAL2,
		ST_PUSH
	} state_t;

	// Mark the bits of word w whose slot number lies below lim.
	function automatic logic [WORD_BITS-1:0] range_mask(input logic [WIDX_W-1:0] w,
		input int unsigned lim);
		logic [WORD_BITS-1:0] m;
		m = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			m[b] = (((32'(w) << OFS_W) + 32'(b)) < lim);
		end
		return m;
	endfunction

	// Return the index of the lowest set bit (0 when none is set).
	function automatic logic [OFS_W-1:0] lowest_set_idx(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] oh;
		logic [OFS_W-1:0]     idx;
		oh  = v & (~v + {{(WORD_BITS-1){1'b0}}, 1'b1});
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (oh[i]) begin
				idx = idx | OFS_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/nps_map.sv =====
// Removed-slot bitmap: word memory with per-word valid and full summary bits.
`default_nettype none

module nps_map #(
	parameter int unsigned SLOTS = nps_pkg::DEF_SLOTS,
	localparam int unsigned LIM = (SLOTS < nps_pkg::POS_SLOTS) ? SLOTS : nps_pkg::POS_SLOTS,
	localparam int unsigned WORDS = (LIM + nps_pkg::WORD_BITS - 1) / nps_pkg::WORD_BITS,
	localparam int unsigned WW = (WORDS > 1) ? $clog2(WORDS) : 1,
	localparam int unsigned DEPTH = 1 << WW
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [WW-1:0]                  rd_addr,
	output logic      [nps_pkg::WORD_BITS-1:0]  rd_word,
	input  wire logic                           wr_en,
	input  wire logic [WW-1:0]                  wr_addr,
	input  wire logic [nps_pkg::WORD_BITS-1:0]  wr_data,
	output logic      [DEPTH-1:0]               full
);
	import nps_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_raw_q;
	logic                 rd_vld_q;
	logic [DEPTH-1:0]     valid_q;
	logic [DEPTH-1:0]     full_q;

	// Read and write the word array
	always_ff @(posedge clk) begin
		rd_raw_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Track written words and words with every in-range slot removed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			full_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				full_q[wr_addr]  <= &(wr_data | ~range_mask(WIDX_W'(wr_addr), LIM));
			end
		end
	end

	// A never-written word reads as all present
	assign rd_word = rd_vld_q ? rd_raw_q : '0;
	assign full    = full_q;

endmodule

`default_nettype wire

// ===== hdl/next_present_slot_finder_top.sv =====
// Top level of the next present slot finder: request control and result output.
//
// Usage:
//   s_axis carries requests: tuser = action (0 query, 1 remove), tdata[9:0] =
//   position. m_axis carries one result per query: tuser = found, tdata[9:0] =
//   next present position (0 when not found). Removes give no result.
//   The set lives in a bitmap of 32-bit words in a registered-read memory,
//   with a flip-flop summary marking words whose slots are all removed.
//   One request is worked at a time. A remove reads the word, then writes it
//   back in ST_WRITE. A query whose start word holds the answer, or that finds
//   no candidate word, raises m_axis_tvalid with the result from ST_EVAL1;
//   one that must move to a later word takes a second memory read and raises
//   it from ST_EVAL2. s_axis_tready returns as the result is loaded, so the next
//   request is taken at the following edge.
//   Requests thus pass at a pace set by the read-modify or read-search of the
//   single memory read port.
//   Reset clears the per-word valid bits and the summary at once, so every slot
//   reads as present with no clearing pass. A stalled receiver holds the result
//   in the output register; removes keep flowing until a finished query must
//   wait in a holding register for it to free up, which blocks new requests.
`default_nettype none

module next_present_slot_finder_top #(
	parameter int unsigned SLOTS = nps_pkg::DEF_SLOTS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// [9:0] position, [15:10] zero
	input  wire logic [nps_pkg::TDATA_W-1:0] s_axis_tdata,
	// [0] action
	input  wire logic                        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// [9:0] next_position, [15:10] zero
	output logic      [nps_pkg::TDATA_W-1:0] m_axis_tdata,
	// [0] found
	output logic                             m_axis_tuser
);
	import nps_pkg::*;

	localparam int unsigned LIM   = (SLOTS < POS_SLOTS) ? SLOTS : POS_SLOTS;
	localparam int unsigned WORDS = (LIM + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned DEPTH = 1 << WW;

	state_t               state_q, state_d;
	logic [WW-1:0]        cur_word_q;
	logic [OFS_W-1:0]     cur_ofs_q;
	logic                 in_rng_q;
	logic [WW-1:0]        nxt_word_q;
	logic                 res_found_q;
	logic [POS_W-1:0]     res_pos_q;
	logic                 m_valid_q;
	logic                 m_found_q;
	logic [POS_W-1:0]     m_pos_q;

	logic [POS_W-1:0]     pos_in;
	logic                 accept;
	logic [WW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_word;
	logic                 wr_en;
	logic [WORD_BITS-1:0] wr_data;
	logic [DEPTH-1:0]     full;
	logic [WORD_BITS-1:0] below;
	logic [WORD_BITS-1:0] cand1;
	logic [WORD_BITS-1:0] cand2;
	logic                 hit1;
	logic [DEPTH-1:0]     nf;
	logic                 has_nf;
	logic [WW-1:0]        nxt_word;
	logic                 emit;
	logic                 emit_go;
	logic                 out_free;
	logic                 res_found;
	logic [POS_W-1:0]     res_pos;

	assign pos_in   = s_axis_tdata[POS_W-1:0];
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	nps_map #(
		.SLOTS(SLOTS)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(rd_addr),
		.rd_word(rd_word),
		.wr_en  (wr_en),
		.wr_addr(cur_word_q),
		.wr_data(wr_data),
		.full   (full)
	);

	// Search the start word at and above the start offset
	assign below = ({{(WORD_BITS-1){1'b0}}, 1'b1} << cur_ofs_q) - {{(WORD_BITS-1){1'b0}}, 1'b1};
	assign cand1 = ~rd_word & range_mask(WIDX_W'(cur_word_q), LIM) & ~below;
	assign hit1  = in_rng_q && (cand1 != '0);

	// Find the first later word that still has a present slot
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			nf[i] = !full[i] && (32'(i) > 32'(cur_word_q)) && (32'(i) < WORDS);
		end
	end
	assign has_nf   = in_rng_q && (nf != '0);
	assign nxt_word = WW'(lowest_set_idx(WORD_BITS'(nf)));

	// Search the later word, which always holds a present slot
	assign cand2 = ~rd_word & range_mask(WIDX_W'(nxt_word_q), LIM);

	// Drive memory access and result selection
	always_comb begin
		rd_addr   = cur_word_q;
		wr_en     = 1'b0;
		wr_data   = rd_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << cur_ofs_q);
		emit      = 1'b0;
		res_found = 1'b0;
		res_pos   = '0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = pos_in[OFS_W +: WW];
			end
			ST_WRITE: begin
				wr_en = in_rng_q;
			end
			ST_EVAL1: begin
				rd_addr = nxt_word;
				if (hit1) begin
					emit      = 1'b1;
					res_found = 1'b1;
					res_pos   = POS_W'({cur_word_q, lowest_set_idx(cand1)});
				end else if (!has_nf) begin
					emit = 1'b1;
				end
			end
			ST_EVAL2: begin
				emit      = 1'b1;
				res_found = 1'b1;
				res_pos   = POS_W'({nxt_word_q, lowest_set_idx(cand2)});
			end
			ST_PUSH: begin
				emit      = 1'b1;
				res_found = res_found_q;
				res_pos   = res_pos_q;
			end
			default: begin
				rd_addr = cur_word_q;
			end
		endcase
	end

	assign emit_go = emit && out_free;

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_axis_tuser == ACT_REMOVE) ? ST_WRITE : ST_EVAL1;
				end
			end
			ST_WRITE: begin
				state_d = ST_IDLE;
			end
			ST_EVAL1: begin
				if (emit) begin
					state_d = emit_go ? ST_IDLE : ST_PUSH;
				end else begin
					state_d = ST_EVAL2;
				end
			end
			ST_EVAL2: begin
				state_d = emit_go ? ST_IDLE : ST_PUSH;
			end
			ST_PUSH: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	// Hold sequencer state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Capture request fields, the pending result and the output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_word_q <= pos_in[OFS_W +: WW];
			cur_ofs_q  <= pos_in[OFS_W-1:0];
			in_rng_q   <= (32'(pos_in) < LIM);
		end
		if (state_q == ST_EVAL1) begin
			nxt_word_q <= nxt_word;
		end
		if (emit && !out_free) begin
			res_found_q <= res_found;
			res_pos_q   <= res_pos;
		end
		if (emit_go) begin
			m_found_q <= res_found;
			m_pos_q   <= res_pos;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_found_q;
	assign m_axis_tdata  = TDATA_W'(m_pos_q);

`include "next_present_slot_finder_top_assert.svh"

	`NPS_ASSERT_NOW(a_found_in_range, m_axis_tvalid && m_axis_tuser, 32'(m_axis_tdata[POS_W-1:0]) < LIM, "found position beyond slot range")
	`NPS_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "not-found result carries nonzero position")
	`NPS_ASSERT_NOW(a_later_word_free, state_q == ST_EVAL2, cand2 != '0, "summary pointed at a word with no present slot")
	`NPS_ASSERT_NEXT(a_query_eval, accept && (s_axis_tuser == ACT_QUERY), state_q == ST_EVAL1, "accepted query did not start its search")

endmodule

`default_nettype wire

// ===== sim/next_present_slot_finder_top_tb.sv =====
// Testbench for the next present slot finder: random and directed requests checked against a bitmap predictor.
`default_nettype none

module next_present_slot_finder_top_tb;

	localparam int unsigned PW             = nps_pkg::POS_W;
	localparam int unsigned TOP_POS        = nps_pkg::POS_SLOTS - 1;
	localparam int unsigned STALL_LIMIT    = 4000;
	localparam int unsigned PHASE_ITEMS    = 200;
	localparam int          RX_HOLD_CYCLES = 120;

	typedef struct packed {
		logic          action;
		logic [PW-1:0] position;
	} request_t;

	typedef struct packed {
		logic          found;
		logic [PW-1:0] next_position;
	} successor_t;

	logic                             clk           = 1'b0;
	logic                             arst_n        = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [nps_pkg::TDATA_W-1:0]      s_axis_tdata  = '0;
	logic                             s_axis_tuser  = nps_pkg::ACT_QUERY;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [nps_pkg::TDATA_W-1:0]      m_axis_tdata;
	logic                             m_axis_tuser;

	// Predictor state: one flag per slot, set once the slot is removed
	bit         slot_gone [nps_pkg::POS_SLOTS];
	request_t   request_q [$];
	successor_t successor_q [$];
	int         tx_idle_pct = 0;
	int         rx_idle_pct = 0;
	bit         rx_hold_req = 1'b0;
	bit         rx_hold_done = 1'b0;
	int         rx_hold_len = 0;
	int         error_count = 0;
	int         stall_cycles = 0;
	bit         req_taken = 1'b0;
	int         run_lo = 0;
	int         run_hi = 0;

	next_present_slot_finder_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Smallest slot at or after start that is still present
	function automatic successor_t predict_successor(input logic [PW-1:0] start);
		successor_t r;
		r = '0;
		for (int p = int'(start); p <= int'(TOP_POS); p++) begin
			if (!slot_gone[p]) begin
				r.found         = 1'b1;
				r.next_position = PW'(p);
				return r;
			end
		end
		return r;
	endfunction

	task automatic add_request(input logic act, input int pos);
		request_t r;
		r.action   = act;
		r.position = PW'(pos);
		request_q.insert(request_q.size(), r);
	endtask

	// Clip a slot number into the field range
	function automatic int clip_pos(input int p);
		if (p < 0) begin
			return 0;
		end
		if (p > int'(TOP_POS)) begin
			return int'(TOP_POS);
		end
		return p;
	endfunction

	// Queue one random burst: a lone request, a query near the last removed run,
	// or a fresh run of removes followed by a query at its start
	task automatic add_burst();
		int pick;
		int start;
		int len;
		pick = $urandom_range(99);
		if (pick < 60) begin
			if ($urandom_range(99) < 30) begin
				add_request(nps_pkg::ACT_REMOVE, $urandom_range(TOP_POS));
			end else begin
				add_request(nps_pkg::ACT_QUERY, $urandom_range(TOP_POS));
			end
		end else if (pick < 85) begin
			add_request(nps_pkg::ACT_QUERY,
				$urandom_range(clip_pos(run_hi + 4), clip_pos(run_lo - 4)));
		end else begin
			start = $urandom_range(TOP_POS);
			len   = $urandom_range(70, 1);
			run_lo = start;
			run_hi = clip_pos(start + len - 1);
			for (int p = run_lo; p <= run_hi; p++) begin
				add_request(nps_pkg::ACT_REMOVE, p);
			end
			add_request(nps_pkg::ACT_QUERY, start);
		end
	endtask

	// Hold until every request has gone in and every result has come back
	task automatic wait_drained();
		while (request_q.size() != 0 || s_axis_tvalid || successor_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Present queued requests, idling at random between them
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || req_taken) begin
				if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nps_pkg::TDATA_W'(request_q[0].position);
					s_axis_tuser  <= request_q[0].action;
					void'(request_q.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Drive the result-side ready: one long hold when asked, otherwise random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold_req && !rx_hold_done) begin
				rx_hold_done  <= 1'b1;
				rx_hold_len   <= RX_HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_hold_len > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold_len   <= rx_hold_len - 1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Predict on accepted requests, check accepted results, watch for a hang
	always @(posedge clk) begin : monitor_proc
		successor_t want;
		logic [PW-1:0] req_pos;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (successor_q.size() == 0) begin
					$display("%0t: unexpected result found=%0b next_position=%0d",
						$time, m_axis_tuser, m_axis_tdata[PW-1:0]);
					error_count++;
				end else begin
					want = successor_q.pop_front();
					if (m_axis_tuser !== want.found) begin
						$display("%0t: found mismatch: expected %0b, actual %0b",
							$time, want.found, m_axis_tuser);
						error_count++;
					end
					if (m_axis_tdata[PW-1:0] !== want.next_position) begin
						$display("%0t: next_position mismatch: expected %0d, actual %0d",
							$time, want.next_position, m_axis_tdata[PW-1:0]);
						error_count++;
					end
				end
			end
			req_taken = s_axis_tvalid && s_axis_tready;
			if (req_taken) begin
				req_pos = s_axis_tdata[PW-1:0];
				if (s_axis_tuser == nps_pkg::ACT_REMOVE) begin
					slot_gone[req_pos] = 1'b1;
				end else begin
					successor_q.insert(successor_q.size(), predict_successor(req_pos));
				end
			end
			if (req_taken || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : stimulus_proc
		int phase_start;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: range ends, repeated removes, the top slot, alternating bits
		tx_idle_pct = 22;
		rx_idle_pct = 71;
		add_request(nps_pkg::ACT_QUERY, 0);
		add_request(nps_pkg::ACT_QUERY, TOP_POS);
		add_request(nps_pkg::ACT_REMOVE, 0);
		add_request(nps_pkg::ACT_QUERY, 0);
		add_request(nps_pkg::ACT_REMOVE, 0);
		add_request(nps_pkg::ACT_QUERY, 0);
		add_request(nps_pkg::ACT_REMOVE, 1);
		add_request(nps_pkg::ACT_QUERY, 0);
		add_request(nps_pkg::ACT_REMOVE, TOP_POS);
		add_request(nps_pkg::ACT_QUERY, TOP_POS);
		add_request(nps_pkg::ACT_QUERY, TOP_POS - 1);
		add_request(nps_pkg::ACT_REMOVE, TOP_POS - 1);
		add_request(nps_pkg::ACT_QUERY, TOP_POS - 1);
		add_request(nps_pkg::ACT_QUERY, 1000);
		add_request(nps_pkg::ACT_REMOVE, 512);
		add_request(nps_pkg::ACT_QUERY, 511);
		add_request(nps_pkg::ACT_QUERY, 512);
		add_request(nps_pkg::ACT_QUERY, 341);
		add_request(nps_pkg::ACT_QUERY, 682);
		add_request(nps_pkg::ACT_REMOVE, 341);
		add_request(nps_pkg::ACT_QUERY, 341);
		wait_drained();

		// Random phases: sender-light/receiver-heavy idling, then reversed, then none but one long receiver hold
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 22;
					rx_idle_pct = 71;
				end
				1: begin
					tx_idle_pct = 71;
					rx_idle_pct = 22;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					rx_hold_req = 1'b1;
				end
			endcase
			phase_start = 0;
			while (phase_start < int'(PHASE_ITEMS)) begin
				phase_start = phase_start - request_q.size();
				add_burst();
				phase_start = phase_start + request_q.size();
			end
			// Pause the sender until every result of this phase is back
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (successor_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, successor_q.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
